// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the UTF-8 escape classifier.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/u8esc_pkg.sv =====
// Package of the UTF-8 escape classifier: token kinds, widths, queue sizing, structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8esc_pkg;

	localparam int unsigned VALUE_W    = 21;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW   = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_PLAIN   = 2'd0,
		KIND_BSLASH  = 2'd1,
		KIND_UNICODE = 2'd2
	} kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		kind_t                kind;
		logic [VALUE_W-1:0]   value;
	} token_t;

	typedef struct packed {
		logic   push;
		token_t token;
	} push_t;

	typedef struct packed {
		logic                full;
		logic                empty;
		logic [QUEUE_CW-1:0] count;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u8esc_front.sv =====
// Front end: accepts bytes, tracks the pending UTF-8 sequence and classifies tokens.
// Depends on u8esc_pkg.
`default_nettype none

module u8esc_front import u8esc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  byte_in,
	input  wire logic        is_last,
	output push_t            push,
	output logic [1:0]       pending
);

	logic [VALUE_W-1:0] partial_q;
	logic [1:0]         remaining_q;
	logic [VALUE_W-1:0] partial_d;
	logic [1:0]         remaining_d;
	logic [VALUE_W-1:0] cont_bits;
	logic [VALUE_W-1:0] merged;
	logic               cont;

	assign cont    = (remaining_q != 2'd0) && (byte_in[7:6] == 2'b10);
	assign merged  = partial_q | cont_bits;
	assign pending = remaining_q;

	always_comb begin
		unique case (remaining_q)
			2'd1:    cont_bits = {15'd0, byte_in[5:0]};
			2'd2:    cont_bits = {9'd0, byte_in[5:0], 6'd0};
			2'd3:    cont_bits = {3'd0, byte_in[5:0], 12'd0};
			default: cont_bits = '0;
		endcase
	end

	always_comb begin
		push.push        = 1'b0;
		push.token.kind  = KIND_PLAIN;
		push.token.value = {13'd0, byte_in};
		partial_d        = '0;
		remaining_d      = 2'd0;
		if (cont) begin
			remaining_d = remaining_q - 2'd1;
			if (remaining_q == 2'd1) begin
				push.push        = accept;
				push.token.kind  = KIND_UNICODE;
				push.token.value = merged;
			end else begin
				partial_d = merged;
			end
		end else if (byte_in == CH_NUL) begin
			push.push        = accept;
			push.token.kind  = KIND_BSLASH;
			push.token.value = {13'd0, CH_ZERO};
		end else if (byte_in == CH_LF) begin
			push.push        = accept;
			push.token.kind  = KIND_BSLASH;
			push.token.value = {13'd0, CH_N};
		end else if (byte_in == CH_BSLASH || byte_in == CH_QUOTE) begin
			push.push        = accept;
			push.token.kind  = KIND_BSLASH;
			push.token.value = {13'd0, byte_in};
		end else if (byte_in[7] == 1'b0) begin
			push.push       = accept;
			push.token.kind = (byte_in < CH_SPACE) ? KIND_UNICODE : KIND_PLAIN;
		end else if (byte_in[7:5] == 3'b110) begin
			partial_d   = {10'd0, byte_in[4:0], 6'd0};
			remaining_d = 2'd1;
		end else if (byte_in[7:4] == 4'b1110) begin
			partial_d   = {5'd0, byte_in[3:0], 12'd0};
			remaining_d = 2'd2;
		end else if (byte_in[7:3] == 5'b11110) begin
			partial_d   = {byte_in[2:0], 18'd0};
			remaining_d = 2'd3;
		end
		if (is_last) begin
			partial_d   = '0;
			remaining_d = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			remaining_q <= 2'd0;
		end else if (accept) begin
			partial_q   <= partial_d;
			remaining_q <= remaining_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/u8esc_queue.sv =====
// Token queue between front and back ends; small register-based FIFO.
// Depends on u8esc_pkg.
`default_nettype none

module u8esc_queue import u8esc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output token_t     head,
	output q_status_t  status
);

	token_t              mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign status.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;
	assign do_push      = push.push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/u8esc_back.sv =====
// Back end: drains the token queue into the output register of the master stream.
// Depends on u8esc_pkg.
`default_nettype none

module u8esc_back import u8esc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_status_t status,
	input  wire token_t    head,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output token_t         out_token
);

	logic   valid_q;
	token_t token_q;

	assign pop       = !status.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_token = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			token_q <= head;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_escape_classifier_unit.sv =====
// Top level of the UTF-8 escape classifier: front end, token queue, back end.
// Depends on u8esc_pkg, u8esc_front, u8esc_queue, u8esc_back, assert_macros.svh.
//
// Usage:
//   Slave stream carries one string byte per word (tdata[7:0]); tlast marks the
//   final byte of a string, after which any unfinished sequence is dropped.
//   Master stream carries one token per word: tdata[20:0] is the value (byte,
//   escape letter or code point), tuser[1:0] the kind (plain, backslash escape,
//   unicode escape). Bytes that end no character produce no word.
//   Throughput: one byte per cycle while the queue is not full; the front end updates
//   its sequence state in the accept cycle and pushes any token into a four-entry queue.
//   Path: an accepted token is written into the queue, moves from the queue head
//   into the output register once that register is free, and is offered from there.
//   Stall: while the receiver holds tready low the queue fills; s_axis_tready
//   drops only when the queue is full, and no token is lost.
//   Reset: arst_n clears the pending sequence, the queue and the output valid.
`default_nettype none

module utf8_escape_classifier_unit import u8esc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_in
	input  wire logic        s_axis_tlast,  // is_last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [20:0] token_value, [23:21] zero
	output logic [1:0]       m_axis_tuser   // [1:0] token_kind
);

`include "assert_macros.svh"

	push_t     push;
	q_status_t status;
	token_t    head;
	token_t    out_token;
	logic      pop;
	logic      accept;
	logic [1:0] pending;

	assign s_axis_tready = !status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata  = {3'd0, out_token.value};
	assign m_axis_tuser  = out_token.kind;

	u8esc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (s_axis_tdata),
		.is_last (s_axis_tlast),
		.push    (push),
		.pending (pending)
	);

	u8esc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.status (status)
	);

	u8esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_token (out_token)
	);

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push.push, !status.full)
	`ASSERT_NEXT(a_last_clears, clk, arst_n, accept && s_axis_tlast, pending == 2'd0)
	`ASSERT_IMPLIES(a_valid_from_queue, clk, arst_n, $rose(m_axis_tvalid), $past(!status.empty))

endmodule

`default_nettype wire

// ===== tb/utf8_escape_classifier_unit_tb.sv =====
// Self-checking testbench for utf8_escape_classifier_unit: streams string bytes in,
// predicts each token and checks every output word in order. Depends on u8esc_pkg.
// Directed bytes cover escapes, stray bytes and broken sequences; random UTF-8 follows.
`default_nettype none

module utf8_escape_classifier_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import u8esc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 310;
	localparam int REPORT_MAX   = 10;

	localparam logic [7:0] ESC_ZERO   = 8'h30;
	localparam logic [7:0] ESC_N      = 8'h6E;
	localparam logic [7:0] ESC_BSLASH = 8'h5C;
	localparam logic [7:0] ESC_QUOTE  = 8'h22;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} str_byte_t;

	typedef struct packed {
		kind_t       kind;
		logic [20:0] value;
	} token_exp_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tready = 1'b0;
	wire logic        s_axis_tready;
	wire logic        m_axis_tvalid;
	wire logic [23:0] m_axis_tdata;
	wire logic [1:0]  m_axis_tuser;

	str_byte_t  byte_backlog[$];
	token_exp_t tokens_due[$];

	logic [20:0] seq_code = '0;
	logic [1:0]  seq_left = '0;

	int  n_pushed  = 0;
	int  n_taken   = 0;
	int  n_fail    = 0;
	int  n_quiet   = 0;
	int  src_idle  = 0;
	int  sink_idle = 0;
	bit  byte_fire = 1'b0;
	bit  tok_fire  = 1'b0;

	utf8_escape_classifier_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// decoder state update for one string byte; returns 1 when a token results
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
			output token_exp_t tok);
		bit hit;
		hit = 1'b0;
		tok = '0;
		if (seq_left != 2'd0 && b[7:6] == 2'b10) begin
			seq_code = seq_code | (21'(b[5:0]) << (6 * (seq_left - 2'd1)));
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				tok.kind  = KIND_UNICODE;
				tok.value = seq_code;
				hit       = 1'b1;
				seq_code  = '0;
			end
		end else begin
			seq_left = '0;
			seq_code = '0;
			hit      = 1'b1;
			if (b == 8'h00) begin
				tok.kind  = KIND_BSLASH;
				tok.value = 21'(ESC_ZERO);
			end else if (b == 8'h0A) begin
				tok.kind  = KIND_BSLASH;
				tok.value = 21'(ESC_N);
			end else if (b == 8'h5C) begin
				tok.kind  = KIND_BSLASH;
				tok.value = 21'(ESC_BSLASH);
			end else if (b == 8'h22) begin
				tok.kind  = KIND_BSLASH;
				tok.value = 21'(ESC_QUOTE);
			end else if (b < 8'h20) begin
				tok.kind  = KIND_UNICODE;
				tok.value = 21'(b);
			end else if (b < 8'h80) begin
				tok.kind  = KIND_PLAIN;
				tok.value = 21'(b);
			end else begin
				hit = 1'b0;
				if (b >= 8'hC0 && b < 8'hE0) begin
					seq_code = 21'(b[4:0]) << 6;
					seq_left = 2'd1;
				end else if (b >= 8'hE0 && b < 8'hF0) begin
					seq_code = 21'(b[3:0]) << 12;
					seq_left = 2'd2;
				end else if (b >= 8'hF0 && b < 8'hF8) begin
					seq_code = 21'(b[2:0]) << 18;
					seq_left = 2'd3;
				end
			end
		end
		if (last) begin
			seq_left = '0;
			seq_code = '0;
		end
		return hit;
	endfunction

	function automatic void note_fail(input string msg);
		n_fail++;
		if (n_fail <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		byte_backlog.push_back('{data: b, last: last});
		n_pushed++;
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	// one character: mostly well-formed, some truncated sequences and raw noise
	task automatic push_random_char();
		int pick;
		int n_cont;
		int keep;
		logic [7:0] lead;
		logic end_last;
		pick = $urandom_range(99);
		if (pick < 30) begin
			push_byte(8'($urandom_range(127)), $urandom_range(15) == 0);
		end else if (pick < 88) begin
			n_cont = $urandom_range(3, 1);
			case (n_cont)
				1: lead = 8'hC0 | 8'($urandom_range(31));
				2: lead = 8'hE0 | 8'($urandom_range(15));
				default: lead = 8'hF0 | 8'($urandom_range(7));
			endcase
			keep     = (pick < 75) ? n_cont : $urandom_range(n_cont - 1);
			end_last = (pick < 75) ? ($urandom_range(15) == 0) : ($urandom_range(2) == 0);
			push_byte(lead, keep == 0 ? end_last : 1'b0);
			for (int i = 0; i < keep; i++)
				push_byte(cont_byte(), i == keep - 1 ? end_last : 1'b0);
		end else begin
			push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
		end
	endtask

	// sample both handshakes, predict accepted bytes, check tokens in order
	always @(posedge clk) begin
		token_exp_t tok;
		token_exp_t want;
		byte_fire = 1'b0;
		tok_fire  = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				byte_fire = 1'b1;
				n_taken++;
				if (decode_byte(s_axis_tdata, s_axis_tlast, tok))
					tokens_due.push_back(tok);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				tok_fire = 1'b1;
				if (tokens_due.size() == 0) begin
					note_fail($sformatf("unexpected word kind=%0d value=%h",
						m_axis_tuser, m_axis_tdata));
				end else begin
					want = tokens_due.pop_front();
					if (m_axis_tuser != want.kind || m_axis_tdata != {3'b000, want.value})
						note_fail($sformatf("mismatch: exp kind=%0d value=%h, got kind=%0d value=%h",
							want.kind, want.value, m_axis_tuser, m_axis_tdata));
				end
			end
			n_quiet = (byte_fire || tok_fire) ? 0 : n_quiet + 1;
			if (n_quiet >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		str_byte_t w;
		m_axis_tready <= ($urandom_range(99) >= sink_idle);
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || byte_fire) begin
			if (byte_backlog.size() != 0 && $urandom_range(99) >= src_idle) begin
				w = byte_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= w.data;
				s_axis_tlast  <= w.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	initial begin
		int start;
		src_idle  = 10;
		sink_idle = 71;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// escapes, controls, plain edge bytes, delete with end of string
		push_byte(8'h00, 1'b0);
		push_byte(8'h0A, 1'b0);
		push_byte(8'h5C, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h7F, 1'b1);
		// stray continuation and invalid leads are dropped
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hF8, 1'b0);
		// two, three and four byte forms, the last one at the largest 21-bit value
		push_byte(8'hC2, 1'b0);
		push_byte(8'hA9, 1'b0);
		push_byte(8'hE2, 1'b0);
		push_byte(8'h82, 1'b0);
		push_byte(8'hAC, 1'b0);
		push_byte(8'hF7, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		// broken sequence, cut-off sequence, overlong form
		push_byte(8'hE2, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'hE2, 1'b0);
		push_byte(8'h82, 1'b1);
		push_byte(8'hC0, 1'b0);
		push_byte(8'h80, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle  = 10;
					sink_idle = 71;
				end
				1: begin
					src_idle  = 71;
					sink_idle = 10;
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
				end
			endcase
			start = n_pushed;
			while (n_pushed - start < PHASE_ITEMS)
				push_random_char();
			while (n_taken != n_pushed)
				@(posedge clk);
		end

		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_fail == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/u8esc_pkg.sv
hw/rtl/u8esc_front.sv
hw/rtl/u8esc_queue.sv
hw/rtl/u8esc_back.sv
hw/rtl/utf8_escape_classifier_unit.sv
tb/utf8_escape_classifier_unit_tb.sv
